// File: rtl/minimal_change_combination_generator_assert.svh
// Assertion macros for the combination generator.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef MINIMAL_CHANGE_COMBINATION_GENERATOR_ASSERT_SVH
`define MINIMAL_CHANGE_COMBINATION_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MCCG_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCCG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mccg_pkg.sv
// Shared types and constants for the combination generator.
// No dependencies; imported by every module of the block.
package mccg_pkg;

    localparam int MAX_SET_SIZE = 32;
    localparam int TW_DEPTH     = MAX_SET_SIZE + 2;
    localparam int AW           = $clog2(TW_DEPTH);
    localparam int TW_W         = AW + 1;

    localparam int CFG_W  = 6;
    localparam int POS_W  = 5;
    localparam int IDX_W  = 6;
    localparam int MASK_W = 32;

    localparam int REG_AW = 1;
    localparam int APB_AW = REG_AW + 2;
    localparam int APB_DW = 32;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = 2 * POS_W + IDX_W + MASK_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [CFG_W-1:0] RST_SELECT_COUNT = CFG_W'(1);
    localparam logic [CFG_W-1:0] RST_SET_SIZE     = CFG_W'(2);

    typedef enum logic {
        OP_RESTART = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    typedef enum logic [REG_AW-1:0] {
        REG_SELECT_COUNT = 1'b0,
        REG_SET_SIZE     = 1'b1
    } t_reg;

    typedef struct packed {
        logic [CFG_W-1:0] select_count;
        logic [CFG_W-1:0] set_size;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] query_position;
    } t_item;

    typedef struct packed {
        logic              done_res;
        logic [POS_W-1:0]  entering_position;
        logic [POS_W-1:0]  leaving_position;
        logic [IDX_W-1:0]  entering_item_index;
        logic [MASK_W-1:0] selection_mask;
        logic              query_active;
    } t_result;

endpackage

// File: rtl/mccg_cfg.sv
// APB register file: select_count and set_size.
// Depends on mccg_pkg.
module mccg_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mccg_pkg::APB_AW-1:0]   paddr,
    input  logic [mccg_pkg::APB_DW-1:0]   pwdata,
    output logic [mccg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output mccg_pkg::t_cfg                o_cfg
);
    import mccg_pkg::*;

    logic [CFG_W-1:0] r_select_count;
    logic [CFG_W-1:0] r_set_size;
    logic             wr;
    t_reg             reg_sel;

    assign pready  = 1'b1;
    assign wr      = psel & penable & pwrite & pready;
    assign reg_sel = t_reg'(paddr[APB_AW-1:2]);

    always_comb begin
        unique case (reg_sel)
            REG_SELECT_COUNT: prdata = {{(APB_DW-CFG_W){1'b0}}, r_select_count};
            REG_SET_SIZE:     prdata = {{(APB_DW-CFG_W){1'b0}}, r_set_size};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select_count <= RST_SELECT_COUNT;
            r_set_size     <= RST_SET_SIZE;
        end else if (wr) begin
            unique case (reg_sel)
                REG_SELECT_COUNT: r_select_count <= pwdata[CFG_W-1:0];
                REG_SET_SIZE:     r_set_size     <= pwdata[CFG_W-1:0];
                default:          r_set_size     <= r_set_size;
            endcase
        end
    end

    assign o_cfg.select_count = r_select_count;
    assign o_cfg.set_size     = r_set_size;

endmodule

// File: rtl/mccg_core.sv
// Twiddle sequencer: twiddle array memory, scan pointer and compare unit.
// Depends on mccg_pkg and the assertion macro header.
module mccg_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mccg_pkg::t_cfg    i_cfg,
    input  logic              i_start,
    input  mccg_pkg::t_item   i_item,
    output logic              o_ready,
    input  logic              i_out_free,
    output logic              o_res_valid,
    output mccg_pkg::t_result o_res
);
    import mccg_pkg::*;
    `include "minimal_change_combination_generator_assert.svh"

    typedef enum logic [3:0] {
        S_FILL, S_IDLE, S_SCAN_J, S_SCAN_K, S_SCAN_Z, S_FLIP, S_FIN_A, S_FIN_B, S_RESULT
    } t_state;

    typedef logic [AW-1:0]         t_addr;
    typedef logic signed [TW_W-1:0] t_tw;

    localparam t_tw TW_ZERO = '0;
    localparam t_tw TW_ONE  = TW_W'(1);
    localparam t_tw TW_NEG1 = TW_W'(-1);
    localparam t_tw TW_NEG2 = TW_W'(-2);
    localparam t_addr A_ONE = AW'(1);
    localparam logic [MAX_SET_SIZE-1:0] BIT0 = {{(MAX_SET_SIZE-1){1'b0}}, 1'b1};

    // twiddle array
    t_tw   mem [TW_DEPTH];
    t_tw   r_rdata;
    logic  wr_en;
    t_addr wr_addr;
    t_addr rd_addr;
    t_tw   wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    t_state                  r_state, n_state;
    logic                    r_init, n_init;
    t_addr                   r_n, n_n;
    t_addr                   r_m, n_m;
    logic [MAX_SET_SIZE-1:0] r_mask, n_mask;
    logic                    r_exh, n_exh;
    t_addr                   r_ptr, n_ptr;
    t_addr                   r_j, n_j;
    t_tw                     r_prev, n_prev;
    t_tw                     r_kval, n_kval;
    t_addr                   r_x, n_x;
    t_addr                   r_y, n_y;
    t_tw                     r_z, n_z;
    logic                    r_done, n_done;
    logic [POS_W-1:0]        r_query, n_query;

    t_addr                   cfg_n, cfg_m;
    t_addr                   lim, ptr_inc, nm, fill_ofs;
    logic                    at_lim, d_pos, d_zero;
    t_tw                     fill_val;
    logic [MAX_SET_SIZE-1:0] fill_bit, mask_step;

    always_comb begin
        if (i_cfg.set_size == '0) begin
            cfg_n = A_ONE;
        end else if (int'(i_cfg.set_size) > MAX_SET_SIZE) begin
            cfg_n = AW'(MAX_SET_SIZE);
        end else begin
            cfg_n = AW'(i_cfg.set_size);
        end
        if (int'(i_cfg.select_count) > int'(cfg_n)) begin
            cfg_m = cfg_n;
        end else begin
            cfg_m = AW'(i_cfg.select_count);
        end
    end

    // compare unit shared by all scan passes
    assign lim      = r_n + A_ONE;
    assign at_lim   = (r_ptr >= lim);
    assign ptr_inc  = at_lim ? r_ptr : r_ptr + A_ONE;
    assign d_pos    = (r_rdata > TW_ZERO);
    assign d_zero   = (r_rdata == TW_ZERO);
    assign nm       = r_n - r_m;
    assign fill_ofs = r_ptr - nm;

    always_comb begin
        if (r_ptr == lim) begin
            fill_val = TW_NEG2;
        end else if (r_m == '0 && r_ptr == A_ONE) begin
            fill_val = TW_ONE;
        end else if (r_ptr <= nm) begin
            fill_val = TW_ZERO;
        end else begin
            fill_val = $signed({1'b0, fill_ofs});
        end
    end

    assign fill_bit  = (r_ptr != lim && r_ptr > nm) ? (BIT0 << (r_ptr - A_ONE)) : '0;
    assign mask_step = (r_mask | (BIT0 << r_x)) & ~(BIT0 << r_y);

    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        n_n     = r_n;
        n_m     = r_m;
        n_mask  = r_mask;
        n_exh   = r_exh;
        n_ptr   = r_ptr;
        n_j     = r_j;
        n_prev  = r_prev;
        n_kval  = r_kval;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_done  = r_done;
        n_query = r_query;
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = TW_ZERO;
        rd_addr = ptr_inc;

        unique case (r_state)
            S_FILL: begin
                wr_en   = 1'b1;
                wr_data = fill_val;
                n_mask  = r_mask | fill_bit;
                if (at_lim) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_RESULT;
                    n_done  = 1'b0;
                    n_x     = '0;
                    n_y     = '0;
                    n_z     = TW_ZERO;
                end else begin
                    n_ptr = r_ptr + A_ONE;
                end
            end
            S_IDLE: begin
                rd_addr = A_ONE;
                if (i_start) begin
                    n_query = i_item.query_position;
                    if (i_item.op == OP_RESTART) begin
                        n_n     = cfg_n;
                        n_m     = cfg_m;
                        n_mask  = '0;
                        n_exh   = 1'b0;
                        n_ptr   = A_ONE;
                        n_state = S_FILL;
                    end else if (r_exh) begin
                        n_done  = 1'b1;
                        n_x     = '0;
                        n_y     = '0;
                        n_z     = TW_ZERO;
                        n_state = S_RESULT;
                    end else begin
                        n_ptr   = A_ONE;
                        n_prev  = TW_ONE;
                        n_state = S_SCAN_J;
                    end
                end
            end
            S_SCAN_J: begin
                if (!at_lim && !d_pos) begin
                    n_prev = r_rdata;
                    n_ptr  = r_ptr + A_ONE;
                end else if (at_lim) begin
                    n_exh   = 1'b1;
                    n_done  = 1'b1;
                    n_x     = '0;
                    n_y     = '0;
                    n_z     = TW_ZERO;
                    n_state = S_RESULT;
                end else begin
                    n_j = r_ptr;
                    if (r_prev == TW_ZERO) begin
                        wr_en   = 1'b1;
                        wr_addr = r_ptr;
                        wr_data = TW_ZERO;
                        n_x     = '0;
                        n_z     = TW_ZERO;
                        n_y     = r_ptr - A_ONE;
                        n_ptr   = A_ONE;
                        n_state = S_FLIP;
                    end else begin
                        if (r_ptr > A_ONE) begin
                            wr_en   = 1'b1;
                            wr_addr = r_ptr - A_ONE;
                            wr_data = TW_ZERO;
                        end
                        n_kval  = r_rdata;
                        n_ptr   = r_ptr + A_ONE;
                        n_state = S_SCAN_K;
                    end
                end
            end
            S_SCAN_K: begin
                if (!at_lim && d_pos) begin
                    n_kval = r_rdata;
                    n_ptr  = r_ptr + A_ONE;
                end else begin
                    n_j     = r_ptr;
                    rd_addr = r_ptr;
                    n_state = S_SCAN_Z;
                end
            end
            S_SCAN_Z: begin
                if (!at_lim && d_zero) begin
                    wr_en   = 1'b1;
                    wr_data = TW_NEG1;
                    n_ptr   = r_ptr + A_ONE;
                end else if (r_rdata == TW_NEG1) begin
                    wr_en   = 1'b1;
                    wr_data = r_kval;
                    n_x     = r_ptr - A_ONE;
                    n_y     = r_j - AW'(2);
                    n_z     = r_kval - TW_ONE;
                    n_state = S_FIN_A;
                end else if (at_lim) begin
                    n_exh   = 1'b1;
                    n_done  = 1'b1;
                    n_x     = '0;
                    n_y     = '0;
                    n_z     = TW_ZERO;
                    n_state = S_RESULT;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_j;
                    wr_data = r_rdata;
                    n_z     = r_rdata - TW_ONE;
                    n_x     = r_j - A_ONE;
                    n_y     = r_ptr - A_ONE;
                    n_state = S_FIN_B;
                end
            end
            S_FLIP: begin
                wr_en   = 1'b1;
                wr_data = (r_ptr == A_ONE) ? TW_ONE : TW_NEG1;
                if (r_ptr + A_ONE >= r_j) begin
                    n_mask  = mask_step;
                    n_done  = 1'b0;
                    n_state = S_RESULT;
                end else begin
                    n_ptr = r_ptr + A_ONE;
                end
            end
            S_FIN_A: begin
                wr_en   = 1'b1;
                wr_addr = r_j - A_ONE;
                wr_data = TW_NEG1;
                n_mask  = mask_step;
                n_done  = 1'b0;
                n_state = S_RESULT;
            end
            S_FIN_B: begin
                wr_en   = 1'b1;
                wr_data = TW_ZERO;
                n_mask  = mask_step;
                n_done  = 1'b0;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_prev  <= n_prev;
        r_kval  <= n_kval;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_done  <= n_done;
        r_query <= n_query;
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_init  <= 1'b1;
            r_n     <= AW'(RST_SET_SIZE);
            r_m     <= AW'(RST_SELECT_COUNT);
            r_mask  <= '0;
            r_exh   <= 1'b0;
            r_ptr   <= A_ONE;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_n     <= n_n;
            r_m     <= n_m;
            r_mask  <= n_mask;
            r_exh   <= n_exh;
            r_ptr   <= n_ptr;
        end
    end

    logic [AW+POS_W-1:0]          x_ext, y_ext;
    logic [TW_W+IDX_W-1:0]        z_ext;
    logic [MAX_SET_SIZE+MASK_W-1:0] m_ext;
    logic [MASK_W-1:0]            mask_out;

    assign x_ext    = {{POS_W{1'b0}}, r_x};
    assign y_ext    = {{POS_W{1'b0}}, r_y};
    assign z_ext    = {{IDX_W{r_z[TW_W-1]}}, r_z};
    assign m_ext    = {{MASK_W{1'b0}}, r_mask};
    assign mask_out = m_ext[MASK_W-1:0];

    assign o_ready                   = (r_state == S_IDLE);
    assign o_res_valid               = (r_state == S_RESULT);
    assign o_res.done_res            = r_done;
    assign o_res.entering_position   = x_ext[POS_W-1:0];
    assign o_res.leaving_position    = y_ext[POS_W-1:0];
    assign o_res.entering_item_index = z_ext[IDX_W-1:0];
    assign o_res.selection_mask      = mask_out;
    assign o_res.query_active        = mask_out[r_query];

    `MCCG_ASSERT_NEXT(a_swap_keeps_count, i_clk, i_rst_n, (r_state == S_FIN_A || r_state == S_FIN_B), ($countones(r_mask) == $countones($past(r_mask))), "swap changed the selected count")
    `MCCG_ASSERT_NEXT(a_exhausted_holds, i_clk, i_rst_n, (r_state == S_IDLE && i_start && i_item.op == OP_ADVANCE && r_exh), (r_state == S_RESULT && r_done && $stable(r_mask)), "advance after exhaustion moved")
    `MCCG_ASSERT_IMPLY(a_scan_in_range, i_clk, i_rst_n, (r_state == S_SCAN_J || r_state == S_SCAN_K || r_state == S_SCAN_Z), (r_ptr <= lim), "scan pointer past sentinel")
    `MCCG_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, (r_state == S_RESULT && !i_out_free), (r_state == S_RESULT && $stable(r_mask) && $stable(r_x)), "pending result lost")

endmodule

// File: rtl/minimal_change_combination_generator.sv
// Top level of the minimal-change combination generator (twiddle scheme).
// Depends on mccg_pkg, mccg_cfg and mccg_core.
//
//  channel   | dir | words
//  s_axis    | in  | tuser: op; tdata: query_position
//  m_axis    | out | tuser: done_res; tdata: positions, item index, mask, query flag
//  apb       | in  | select_count at 0x0, set_size at 0x4
//
// Restart: the array is refilled one entry per cycle for the clamped set_size.
// Advance: straight to the result when already exhausted; else set by the element scan
// through the array's single read port, longer when the front run is rewritten after the scan.
// One word at a time; s_axis_tready is low from accept until the result enters the output register.
// After reset the array is filled for the default config while s_axis_tready is low.
// The output register holds a result while m_axis_tready is low; the next word may be accepted.
module minimal_change_combination_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [4:0] query_position, [7:5] zero
    input  logic [mccg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] op
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [4:0] entering_position, [9:5] leaving_position, [15:10] entering_item_index,
    // [47:16] selection_mask, [48] query_active, [55:49] zero
    output logic [mccg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] done_res
    output logic                               m_axis_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mccg_pkg::APB_AW-1:0]        paddr,
    input  logic [mccg_pkg::APB_DW-1:0]        pwdata,
    output logic [mccg_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import mccg_pkg::*;

    t_cfg    cfg;
    t_item   item;
    t_result res;
    logic    core_ready;
    logic    res_valid;
    logic    out_free;
    logic    r_out_valid;
    t_result r_out;

    mccg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign item.op             = t_op'(s_axis_tuser);
    assign item.query_position = s_axis_tdata[POS_W-1:0];
    assign s_axis_tready       = core_ready;
    assign out_free            = !r_out_valid || m_axis_tready;

    mccg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_start     (s_axis_tvalid && core_ready),
        .i_item      (item),
        .o_ready     (core_ready),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out <= res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.done_res;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}},
                            r_out.query_active,
                            r_out.selection_mask,
                            r_out.entering_item_index,
                            r_out.leaving_position,
                            r_out.entering_position};

endmodule

// File: sim/tb_minimal_change_combination_generator.sv
// Self-checking bench for the twiddle combination generator: random restart/advance words,
// register phases over APB and a built-in predictor of the twiddle array and selection mask.
// Depends on mccg_pkg and minimal_change_combination_generator.
module tb_minimal_change_combination_generator;
    import mccg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 550;

    typedef struct {
        t_op              op;
        logic [POS_W-1:0] query;
        bit               drain_first;
    } t_gen_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    // predictor state
    int                tw_arr [TW_DEPTH];
    logic [MASK_W-1:0] sel_mask;
    bit                combos_exhausted;
    int                n_active;
    logic [CFG_W-1:0]  cfg_select_count;
    logic [CFG_W-1:0]  cfg_set_size;

    t_gen_word pending_words[$];
    t_result   predicted_steps[$];
    t_gen_word held_word;
    bit        word_held = 1'b0;
    int        items_queued = 0;
    int        errors = 0;
    int        tx_mode = 0;
    int        rx_mode = 0;
    int        gap_cnt = 0;
    int        stall_cnt = 0;
    int        quiet_cycles = 0;
    t_result   got_res;
    t_result   want_res;

    minimal_change_combination_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void twiddle_restart();
        int n;
        int m;
        int i;
        n = int'(cfg_set_size);
        if (n < 1) n = 1;
        if (n > MAX_SET_SIZE) n = MAX_SET_SIZE;
        m = int'(cfg_select_count);
        if (m > n) m = n;
        n_active  = n;
        tw_arr[0] = n + 1;
        for (i = 1; i <= n; i++)
            tw_arr[i] = (i <= n - m) ? 0 : i + m - n;
        tw_arr[n + 1] = -2;
        if (m == 0) tw_arr[1] = 1;
        sel_mask = '0;
        for (i = n - m; i < n; i++)
            sel_mask[i] = 1'b1;
        combos_exhausted = 1'b0;
    endfunction

    // one twiddle step; returns 0 when no further combination exists
    function automatic bit twiddle_step(output int x, output int y, output int z);
        int lim;
        int i;
        int j;
        int k;
        x = 0;
        y = 0;
        z = 0;
        lim = n_active + 1;
        j = 1;
        while (j < lim && tw_arr[j] <= 0) j++;
        if (j >= lim) return 1'b0;
        if (tw_arr[j - 1] == 0) begin
            for (i = j - 1; i > 1; i--) tw_arr[i] = -1;
            tw_arr[j] = 0;
            tw_arr[1] = 1;
            y = j - 1;
        end else begin
            if (j > 1) tw_arr[j - 1] = 0;
            do j++; while (j < lim && tw_arr[j] > 0);
            k = j - 1;
            i = j;
            while (i < lim && tw_arr[i] == 0) begin
                tw_arr[i] = -1;
                i++;
            end
            if (tw_arr[i] == -1) begin
                tw_arr[i] = tw_arr[k];
                z = tw_arr[k] - 1;
                x = i - 1;
                y = k - 1;
                tw_arr[k] = -1;
            end else if (i >= lim) begin
                return 1'b0;
            end else begin
                tw_arr[j] = tw_arr[i];
                z = tw_arr[i] - 1;
                tw_arr[i] = 0;
                x = j - 1;
                y = i - 1;
            end
        end
        sel_mask[x] = 1'b1;
        sel_mask[y] = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_result predict_step(t_gen_word w);
        t_result r;
        int x;
        int y;
        int z;
        x = 0;
        y = 0;
        z = 0;
        r.done_res = 1'b0;
        if (w.op == OP_RESTART) begin
            twiddle_restart();
        end else if (combos_exhausted) begin
            r.done_res = 1'b1;
        end else if (!twiddle_step(x, y, z)) begin
            x = 0;
            y = 0;
            z = 0;
            combos_exhausted = 1'b1;
            r.done_res = 1'b1;
        end
        r.entering_position   = x[POS_W-1:0];
        r.leaving_position    = y[POS_W-1:0];
        r.entering_item_index = z[IDX_W-1:0];
        r.selection_mask      = sel_mask;
        r.query_active        = sel_mask[w.query];
        return r;
    endfunction

    function automatic int pick_gap(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0) return 0;
        if (mode == 1) return (r < 70) ? 0 : $urandom_range(1, 3);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [POS_W-1:0] rand_query(int n);
        int top;
        top = (n < 1) ? 0 : (n > MAX_SET_SIZE ? MAX_SET_SIZE - 1 : n - 1);
        if ($urandom_range(0, 2) == 0) return POS_W'($urandom_range(0, 31));
        return POS_W'($urandom_range(0, top));
    endfunction

    function automatic void push_word(t_op op, logic [POS_W-1:0] q, bit drain);
        pending_words.push_back('{op, q, drain});
        items_queued++;
    endfunction

    task automatic wait_idle();
        while (pending_words.size() != 0 || predicted_steps.size() != 0 || word_held)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SELECT_COUNT) cfg_select_count = value;
        else cfg_set_size = value;
    endtask

    task automatic configure(logic [CFG_W-1:0] m, logic [CFG_W-1:0] n);
        wait_idle();
        write_reg(REG_SELECT_COUNT, m);
        write_reg(REG_SET_SIZE, n);
        tx_mode = $urandom_range(0, 2);
        rx_mode = $urandom_range(0, 2);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_cnt = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_steps.push_back(predict_step(held_word));
                word_held = 1'b0;
                gap_cnt = pick_gap(tx_mode);
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                s_axis_tvalid <= 1'b1;
            end else if (gap_cnt != 0) begin
                gap_cnt--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() != 0 &&
                         (!pending_words[0].drain_first || predicted_steps.size() == 0)) begin
                held_word = pending_words.pop_front();
                word_held = 1'b1;
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= held_word.op;
                s_axis_tdata  <= IN_TDATA_W'(held_word.query);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res.done_res            = m_axis_tuser;
                got_res.entering_position   = m_axis_tdata[4:0];
                got_res.leaving_position    = m_axis_tdata[9:5];
                got_res.entering_item_index = m_axis_tdata[15:10];
                got_res.selection_mask      = m_axis_tdata[47:16];
                got_res.query_active        = m_axis_tdata[48];
                if (predicted_steps.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word done=%0b tdata=%h", $time,
                             m_axis_tuser, m_axis_tdata);
                end else begin
                    want_res = predicted_steps.pop_front();
                    if (got_res !== want_res) begin
                        errors++;
                        $display("%0t: mismatch exp done=%0b ent=%0d lve=%0d idx=%0d mask=%h q=%0b",
                                 $time, want_res.done_res, want_res.entering_position,
                                 want_res.leaving_position, $signed(want_res.entering_item_index),
                                 want_res.selection_mask, want_res.query_active);
                        $display("%0t:          got done=%0b ent=%0d lve=%0d idx=%0d mask=%h q=%0b",
                                 $time, got_res.done_res, got_res.entering_position,
                                 got_res.leaving_position, $signed(got_res.entering_item_index),
                                 got_res.selection_mask, got_res.query_active);
                    end
                end
            end
            if (stall_cnt != 0) begin
                stall_cnt--;
                m_axis_tready <= 1'b0;
            end else if (rx_mode != 0 && $urandom_range(0, 3) == 0) begin
                stall_cnt = pick_gap(rx_mode);
                m_axis_tready <= (stall_cnt == 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int               r;
        int               i;
        int               n;
        int               m;
        int               mm;
        int               steps;
        longint           combos;
        cfg_select_count = RST_SELECT_COUNT;
        cfg_set_size     = RST_SET_SIZE;
        twiddle_restart();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config (m=1, n=2): walk past the end, then restart
        push_word(OP_ADVANCE, 5'd0, 1'b0);
        push_word(OP_ADVANCE, 5'd1, 1'b0);
        push_word(OP_ADVANCE, 5'd1, 1'b0);
        push_word(OP_ADVANCE, 5'd31, 1'b0);
        push_word(OP_RESTART, 5'd31, 1'b0);
        push_word(OP_ADVANCE, 5'd0, 1'b1);
        // new registers take effect only at restart; m=0 is a single combination
        configure(6'd0, 6'd5);
        push_word(OP_ADVANCE, 5'd4, 1'b0);
        push_word(OP_RESTART, 5'd4, 1'b0);
        push_word(OP_ADVANCE, 5'd4, 1'b0);
        configure(6'd32, 6'd32);
        push_word(OP_RESTART, 5'd31, 1'b0);
        push_word(OP_ADVANCE, 5'd0, 1'b0);
        push_word(OP_ADVANCE, 5'd31, 1'b0);
        // m clamped to n, n clamped to 1..32
        configure(6'd40, 6'd4);
        push_word(OP_RESTART, 5'd3, 1'b0);
        push_word(OP_ADVANCE, 5'd3, 1'b0);
        configure(6'd1, 6'd0);
        push_word(OP_RESTART, 5'd0, 1'b0);
        push_word(OP_ADVANCE, 5'd0, 1'b0);
        push_word(OP_ADVANCE, 5'd1, 1'b0);
        configure(6'd63, 6'd63);
        push_word(OP_RESTART, 5'd31, 1'b0);
        push_word(OP_ADVANCE, 5'd31, 1'b0);
        configure(6'd1, 6'd32);
        push_word(OP_RESTART, 5'd0, 1'b0);
        push_word(OP_ADVANCE, 5'd31, 1'b0);
        push_word(OP_ADVANCE, 5'd0, 1'b0);
        push_word(OP_ADVANCE, 5'd31, 1'b0);

        while (items_queued < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            if (r < 7) n = $urandom_range(1, 8);
            else if (r < 9) n = $urandom_range(9, 31);
            else n = MAX_SET_SIZE;
            m = ($urandom_range(0, 7) == 0) ? $urandom_range(n, n + 2) : $urandom_range(0, n);
            configure(CFG_W'(m), CFG_W'(n));
            mm = (m > n) ? n : m;
            combos = 1;
            for (i = 0; i < mm && combos <= 64; i++)
                combos = combos * (n - i) / (i + 1);
            steps = ((combos > 60) ? 60 : int'(combos)) + $urandom_range(0, 3);
            // occasionally keep stepping the previous sequence
            if ($urandom_range(0, 7) != 0)
                push_word(OP_RESTART, rand_query(n), 1'b0);
            for (i = 0; i < steps; i++) begin
                r = $urandom_range(0, 99);
                push_word((r < 5) ? OP_RESTART : OP_ADVANCE, rand_query(n), r >= 97);
            end
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && predicted_steps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/mccg_pkg.sv
rtl/mccg_cfg.sv
rtl/mccg_core.sv
rtl/minimal_change_combination_generator.sv
sim/tb_minimal_change_combination_generator.sv
